[sv/assert_macros.svh]
// assertion macros shared by the search controller rtl
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property checked on every clock edge outside reset
`define BGSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// condition in one cycle implies a condition in the next
`define BGSM_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);
`endif

[sv/bgsm_pkg.sv]
// types, codes and constants of the bracket and golden-section search controller
// no dependencies
package bgsm_pkg;

  localparam int unsigned MulW = 34;
  localparam int unsigned DivW = 64;
  localparam int unsigned DvsW = 34;

  typedef logic signed [MulW-1:0]   mul_op_t;
  typedef logic signed [2*MulW-1:0] wide_t;

  localparam logic [1:0] CMD_BRACKET = 2'd0;
  localparam logic [1:0] CMD_GOLDEN  = 2'd1;
  localparam logic [1:0] CMD_REPLY   = 2'd2;
  localparam logic [1:0] CMD_NONE    = 2'd3;

  localparam logic [1:0] KIND_PROBE   = 2'd0;
  localparam logic [1:0] KIND_BRACKET = 2'd1;
  localparam logic [1:0] KIND_MINIMUM = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  localparam mul_op_t GoldQ24   = 34'sd27146106;
  localparam mul_op_t RatioQ24  = 34'sd10368890;
  localparam mul_op_t CompQ24   = 34'sd6408326;
  localparam mul_op_t GrowLimit = 34'sd100;
  localparam logic [23:0] TolReset = 24'd168;
  localparam logic [32:0] WidthFloor = 33'd4;

  localparam wide_t SatMax = wide_t'(32'sh7fffffff);
  localparam wide_t SatMin = ~SatMax;
  localparam wide_t HalfQ24 = wide_t'(1) <<< 23;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic signed [31:0] probe_point;
    logic signed [31:0] bracket_low;
    logic signed [31:0] bracket_mid;
    logic signed [31:0] bracket_high;
    logic signed [31:0] value_low;
    logic signed [31:0] value_mid;
    logic signed [31:0] value_high;
    logic signed [31:0] minimum_point;
    logic signed [31:0] minimum_value;
  } out_item_t;

  function automatic logic signed [31:0] sat32(input wide_t v);
    logic signed [31:0] r;
    if (v > SatMax) begin
      r = 32'sh7fffffff;
    end else if (v < SatMin) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic wide_t ext(input logic signed [31:0] x);
    return wide_t'(x);
  endfunction

  function automatic wide_t rnd24(input wide_t v);
    return (v + HalfQ24) >>> 24;
  endfunction

endpackage

[sv/bgsm_if.sv]
// handshake channels of the search controller: input items, results, tolerance writes
// no dependencies
interface bgsm_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [31:0] start_low;
  logic signed [31:0] start_mid;
  logic signed [31:0] start_high;
  logic signed [31:0] function_value;
  modport source (output valid, command, start_low, start_mid, start_high, function_value,
                  input ready);
  modport sink (input valid, command, start_low, start_mid, start_high, function_value,
                output ready);
endinterface

interface bgsm_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         result_kind;
  logic signed [31:0] probe_point;
  logic signed [31:0] bracket_low;
  logic signed [31:0] bracket_mid;
  logic signed [31:0] bracket_high;
  logic signed [31:0] value_low;
  logic signed [31:0] value_mid;
  logic signed [31:0] value_high;
  logic signed [31:0] minimum_point;
  logic signed [31:0] minimum_value;
  modport source (output valid, result_kind, probe_point, bracket_low, bracket_mid,
                  bracket_high, value_low, value_mid, value_high, minimum_point,
                  minimum_value, input ready);
  modport sink (input valid, result_kind, probe_point, bracket_low, bracket_mid,
                bracket_high, value_low, value_mid, value_high, minimum_point,
                minimum_value, output ready);
endinterface

interface bgsm_cfg_if;
  logic        valid;
  logic        ready;
  logic [23:0] tolerance;
  modport source (output valid, tolerance, input ready);
  modport sink (input valid, tolerance, output ready);
endinterface

[sv/bracket_and_golden_section_minimizer.sv]
// each command is handled in turn: a start, a reply that only probes (with or without a golden
// outward step), a bracket test that stops, or one that goes on through the radix-2 divider
// (again with or without a golden outward step), and a golden test with or without a new
// interior point; a stalled output adds its stall
// throughput: one item at a time, the next taken once the result sits in the output register
// asynchronous active-low reset: search idle, tolerance 168, output empty
`include "assert_macros.svh"
module bracket_and_golden_section_minimizer import bgsm_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bgsm_in_if.sink    in_i,
  bgsm_out_if.source out_o,
  bgsm_cfg_if.sink   cfg_i
);
  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_B_FA    = 4'd1;
  localparam logic [3:0] PH_B_FB    = 4'd2;
  localparam logic [3:0] PH_B_FC    = 4'd3;
  localparam logic [3:0] PH_B_IN    = 4'd4;
  localparam logic [3:0] PH_B_OUT   = 4'd5;
  localparam logic [3:0] PH_B_SHIFT = 4'd6;
  localparam logic [3:0] PH_G_F1    = 4'd7;
  localparam logic [3:0] PH_G_F2    = 4'd8;
  localparam logic [3:0] PH_G_N1    = 4'd9;
  localparam logic [3:0] PH_G_N2    = 4'd10;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_G0M  = 5'd1;
  localparam logic [4:0] S_G0R  = 5'd2;
  localparam logic [4:0] S_B1M  = 5'd3;
  localparam logic [4:0] S_B1R  = 5'd4;
  localparam logic [4:0] S_GE0  = 5'd5;
  localparam logic [4:0] S_GE1  = 5'd6;
  localparam logic [4:0] S_GE2  = 5'd7;
  localparam logic [4:0] S_BT0  = 5'd8;
  localparam logic [4:0] S_BT1  = 5'd9;
  localparam logic [4:0] S_BT2  = 5'd10;
  localparam logic [4:0] S_BT3  = 5'd11;
  localparam logic [4:0] S_BT4  = 5'd12;
  localparam logic [4:0] S_BT5  = 5'd13;
  localparam logic [4:0] S_BT6  = 5'd14;
  localparam logic [4:0] S_BT7  = 5'd15;
  localparam logic [4:0] S_BT8  = 5'd16;
  localparam logic [4:0] S_BTW  = 5'd17;
  localparam logic [4:0] S_BTC  = 5'd18;
  localparam logic [4:0] S_GT0  = 5'd19;
  localparam logic [4:0] S_GT1  = 5'd20;
  localparam logic [4:0] S_GT2  = 5'd21;
  localparam logic [4:0] S_CB0  = 5'd22;
  localparam logic [4:0] S_CB1  = 5'd23;
  localparam logic [4:0] S_CB2  = 5'd24;
  localparam logic [4:0] S_EMIT = 5'd25;

  localparam wide_t FracHalf = wide_t'(1) <<< (FRAC_BITS - 1);

  logic [4:0]  st_q;
  logic [3:0]  phase_q;
  logic [23:0] tol_q;
  logic        out_valid_q;
  out_item_t   out_q, res_q;

  logic signed [31:0] pa_q, pb_q, pc_q, pu_q;
  logic signed [31:0] fa_q, fb_q, fc_q;
  logic signed [31:0] ulim_q;
  logic signed [31:0] t1_q, t2_q, t3_q, t4_q;
  logic signed [32:0] den_q;
  logic [32:0]        w_q, scale_q;
  wide_t              acc_q;
  logic               flag_q, qneg_q;

  mul_op_t            mul_a, mul_b;
  wide_t              prod;
  logic               div_busy;
  logic [DivW-1:0]    div_quo;

  logic               in_beat, out_beat;
  logic signed [31:0] fv;
  wide_t              d_cb, d_ba, abs_cb, abs_ba;
  logic               far_side, swap;
  logic signed [31:0] na, nb;
  logic signed [31:0] mk, rndf, t_ext, c_abs, u_ge, comb_r, u_par;
  wide_t              num_w, num_abs, qs;
  logic signed [32:0] den_abs, den_mag, d30, w_abs;
  logic [32:0]        abs_b, abs_c;
  logic               bt_stop, gt_cont, c1, c2, c3;

  bgsm_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  bgsm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (st_q == S_BT6),
    .dividend_i (num_abs[DivW-1:0]),
    .divisor_i  ({den_mag, 1'b0}),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  assign in_i.ready  = (st_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_beat     = in_i.valid && in_i.ready;
  assign out_beat    = out_valid_q && out_o.ready;
  assign fv          = in_i.function_value;

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (st_q)
      S_G0M: begin
        mul_a = mul_op_t'(t1_q);
        mul_b = CompQ24;
      end
      S_B1M, S_GE1: begin
        mul_a = mul_op_t'(t1_q);
        mul_b = GoldQ24;
      end
      S_BT1, S_BT5: begin
        mul_a = mul_op_t'(t1_q);
        mul_b = mul_op_t'(t3_q);
      end
      S_BT2, S_BT4: begin
        mul_a = mul_op_t'(t2_q);
        mul_b = mul_op_t'(t4_q);
      end
      S_BT7: begin
        mul_a = mul_op_t'(t1_q);
        mul_b = GrowLimit;
      end
      S_GT1: begin
        mul_a = {1'b0, scale_q};
        mul_b = {10'd0, tol_q};
      end
      S_CB0: begin
        mul_a = mul_op_t'(t1_q);
        mul_b = RatioQ24;
      end
      S_CB1: begin
        mul_a = mul_op_t'(t2_q);
        mul_b = CompQ24;
      end
      default: ;
    endcase
  end

  always_comb begin
    d_cb     = ext(in_i.start_high) - ext(in_i.start_mid);
    d_ba     = ext(in_i.start_mid) - ext(in_i.start_low);
    abs_cb   = d_cb[2*MulW-1] ? -d_cb : d_cb;
    abs_ba   = d_ba[2*MulW-1] ? -d_ba : d_ba;
    far_side = abs_cb > abs_ba;
    swap     = fv > fa_q;
    na       = swap ? pb_q : pa_q;
    nb       = swap ? pa_q : pb_q;

    mk       = sat32(rnd24(prod));
    rndf     = sat32((prod + FracHalf) >>> FRAC_BITS);
    t_ext    = sat32(ext(pb_q) + ext(mk));
    c_abs    = sat32(t_ext[31] ? -ext(t_ext) : ext(t_ext));
    u_ge     = sat32(ext(pc_q) + ext(mk));
    comb_r   = sat32(rnd24(acc_q + prod));

    num_w    = acc_q - prod;
    num_abs  = num_w[2*MulW-1] ? -num_w : num_w;
    den_abs  = den_q[32] ? -den_q : den_q;
    den_mag  = (den_abs == '0) ? 33'sd1 : den_abs;
    qs       = qneg_q ? -wide_t'({4'd0, div_quo}) : wide_t'({4'd0, div_quo});
    u_par    = sat32(ext(pb_q) - qs);

    bt_stop  = (fb_q < fc_q) || (fb_q == '0 && fc_q == '0) || (pb_q == pc_q);
    c1 = (pb_q > pu_q && pu_q > pc_q) || (pb_q < pu_q && pu_q < pc_q);
    c2 = (pc_q > pu_q && pu_q > ulim_q) || (pc_q < pu_q && pu_q < ulim_q);
    c3 = (pu_q == ulim_q) || (ulim_q == pc_q) || (pu_q > ulim_q && ulim_q > pc_q) ||
         (pu_q < ulim_q && ulim_q < pc_q);

    d30      = {pu_q[31], pu_q} - {pa_q[31], pa_q};
    w_abs    = d30[32] ? -d30 : d30;
    abs_b    = pb_q[31] ? -{pb_q[31], pb_q} : {pb_q[31], pb_q};
    abs_c    = pc_q[31] ? -{pc_q[31], pc_q} : {pc_q[31], pc_q};
    gt_cont  = (w_q > WidthFloor) && ({w_q, 24'd0} > prod[56:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      phase_q     <= PH_IDLE;
      tol_q       <= TolReset;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      res_q       <= '0;
      pa_q <= '0; pb_q <= '0; pc_q <= '0; pu_q <= '0;
      fa_q <= '0; fb_q <= '0; fc_q <= '0;
      ulim_q <= '0;
      t1_q <= '0; t2_q <= '0; t3_q <= '0; t4_q <= '0;
      den_q <= '0; w_q <= '0; scale_q <= '0; acc_q <= '0;
      flag_q <= 1'b0; qneg_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        tol_q <= cfg_i.tolerance;
      end
      if (out_beat && (st_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (st_q)
        S_IDLE: if (in_beat) begin
          unique case (in_i.command)
            CMD_BRACKET: begin
              pa_q <= in_i.start_low;
              pb_q <= in_i.start_mid;
              phase_q <= PH_B_FA;
              res_q.result_kind <= KIND_PROBE;
              res_q.probe_point <= in_i.start_low;
              st_q <= S_EMIT;
            end
            CMD_GOLDEN: begin
              pa_q   <= in_i.start_low;
              pu_q   <= in_i.start_high;
              flag_q <= far_side;
              if (far_side) begin
                pb_q <= in_i.start_mid;
                t1_q <= sat32(d_cb);
              end else begin
                pc_q <= in_i.start_mid;
                t1_q <= sat32(d_ba);
              end
              phase_q <= PH_G_F1;
              st_q <= S_G0M;
            end
            CMD_REPLY: begin
              unique case (phase_q)
                PH_B_FA: begin
                  fa_q <= fv;
                  phase_q <= PH_B_FB;
                  res_q.probe_point <= pb_q;
                  st_q <= S_EMIT;
                end
                PH_B_FB: begin
                  pa_q <= na;
                  pb_q <= nb;
                  fa_q <= swap ? fv : fa_q;
                  fb_q <= swap ? fa_q : fv;
                  t1_q <= sat32(ext(nb) - ext(na));
                  st_q <= S_B1M;
                end
                PH_B_FC: begin
                  fc_q <= fv;
                  st_q <= S_BT0;
                end
                PH_B_IN: begin
                  if (fv < fc_q) begin
                    pa_q <= pb_q; fa_q <= fb_q;
                    pb_q <= pu_q; fb_q <= fv;
                    st_q <= S_BT0;
                  end else if (fv > fb_q) begin
                    pc_q <= pu_q; fc_q <= fv;
                    st_q <= S_BT0;
                  end else begin
                    st_q <= S_GE0;
                  end
                end
                PH_B_OUT: begin
                  if (fv < fc_q) begin
                    pb_q <= pc_q; pc_q <= pu_q;
                    fb_q <= fc_q; fc_q <= fv;
                    st_q <= S_GE0;
                  end else begin
                    pa_q <= pb_q; pb_q <= pc_q; pc_q <= pu_q;
                    fa_q <= fb_q; fb_q <= fc_q; fc_q <= fv;
                    st_q <= S_BT0;
                  end
                end
                PH_B_SHIFT: begin
                  pa_q <= pb_q; pb_q <= pc_q; pc_q <= pu_q;
                  fa_q <= fb_q; fb_q <= fc_q; fc_q <= fv;
                  st_q <= S_BT0;
                end
                PH_G_F1: begin
                  fa_q <= fv;
                  phase_q <= PH_G_F2;
                  res_q.probe_point <= pc_q;
                  st_q <= S_EMIT;
                end
                PH_G_F2, PH_G_N2: begin
                  fb_q <= fv;
                  st_q <= S_GT0;
                end
                PH_G_N1: begin
                  fa_q <= fv;
                  st_q <= S_GT0;
                end
                default: begin
                  phase_q <= PH_IDLE;
                  res_q.result_kind <= KIND_ERROR;
                  st_q <= S_EMIT;
                end
              endcase
            end
            default: ;
          endcase
        end
        S_G0M: st_q <= S_G0R;
        S_G0R: begin
          if (flag_q) begin
            pc_q <= sat32(ext(pb_q) + ext(mk));
            res_q.probe_point <= pb_q;
          end else begin
            pb_q <= sat32(ext(pc_q) - ext(mk));
            res_q.probe_point <= sat32(ext(pc_q) - ext(mk));
          end
          st_q <= S_EMIT;
        end
        S_B1M: st_q <= S_B1R;
        S_B1R: begin
          pc_q <= c_abs;
          phase_q <= PH_B_FC;
          res_q.probe_point <= c_abs;
          st_q <= S_EMIT;
        end
        S_GE0: begin
          t1_q <= sat32(ext(pc_q) - ext(pb_q));
          st_q <= S_GE1;
        end
        S_GE1: st_q <= S_GE2;
        S_GE2: begin
          pu_q <= u_ge;
          phase_q <= PH_B_SHIFT;
          res_q.probe_point <= u_ge;
          st_q <= S_EMIT;
        end
        S_BT0: begin
          if (bt_stop) begin
            phase_q <= PH_IDLE;
            res_q.result_kind  <= KIND_BRACKET;
            res_q.bracket_low  <= pa_q;
            res_q.bracket_mid  <= pb_q;
            res_q.bracket_high <= pc_q;
            res_q.value_low    <= fa_q;
            res_q.value_mid    <= fb_q;
            res_q.value_high   <= fc_q;
            st_q <= S_EMIT;
          end else begin
            t1_q <= sat32(ext(pb_q) - ext(pa_q));
            t2_q <= sat32(ext(pb_q) - ext(pc_q));
            t3_q <= sat32(ext(fb_q) - ext(fc_q));
            t4_q <= sat32(ext(fb_q) - ext(fa_q));
            st_q <= S_BT1;
          end
        end
        S_BT1: st_q <= S_BT2;
        S_BT2: begin
          t3_q <= rndf;
          st_q <= S_BT3;
        end
        S_BT3: begin
          t4_q <= rndf;
          st_q <= S_BT4;
        end
        S_BT4: begin
          den_q <= {t4_q[31], t4_q} - {t3_q[31], t3_q};
          st_q <= S_BT5;
        end
        S_BT5: begin
          acc_q <= prod;
          st_q <= S_BT6;
        end
        S_BT6: begin
          qneg_q <= num_w[2*MulW-1] ^ (den_q[32] || den_q == '0);
          t1_q <= sat32(ext(pc_q) - ext(pb_q));
          st_q <= S_BT7;
        end
        S_BT7: st_q <= S_BT8;
        S_BT8: begin
          ulim_q <= sat32(ext(pb_q) + ext(sat32(prod)));
          st_q <= S_BTW;
        end
        S_BTW: if (!div_busy) begin
          pu_q <= u_par;
          st_q <= S_BTC;
        end
        S_BTC: begin
          if (c1) begin
            phase_q <= PH_B_IN;
            res_q.probe_point <= pu_q;
            st_q <= S_EMIT;
          end else if (c2) begin
            phase_q <= PH_B_OUT;
            res_q.probe_point <= pu_q;
            st_q <= S_EMIT;
          end else if (c3) begin
            pu_q <= ulim_q;
            phase_q <= PH_B_SHIFT;
            res_q.probe_point <= ulim_q;
            st_q <= S_EMIT;
          end else begin
            st_q <= S_GE0;
          end
        end
        S_GT0: begin
          w_q     <= w_abs;
          scale_q <= abs_b + abs_c;
          st_q    <= S_GT1;
        end
        S_GT1: st_q <= S_GT2;
        S_GT2: begin
          if (gt_cont) begin
            if (fb_q < fa_q) begin
              pa_q <= pb_q; pb_q <= pc_q; fa_q <= fb_q;
              t1_q <= pc_q; t2_q <= pu_q;
              flag_q <= 1'b1;
              phase_q <= PH_G_N2;
            end else begin
              pu_q <= pc_q; pc_q <= pb_q; fb_q <= fa_q;
              t1_q <= pb_q; t2_q <= pa_q;
              flag_q <= 1'b0;
              phase_q <= PH_G_N1;
            end
            st_q <= S_CB0;
          end else begin
            phase_q <= PH_IDLE;
            res_q.result_kind   <= KIND_MINIMUM;
            res_q.minimum_point <= (fa_q < fb_q) ? pb_q : pc_q;
            res_q.minimum_value <= (fa_q < fb_q) ? fa_q : fb_q;
            st_q <= S_EMIT;
          end
        end
        S_CB0: st_q <= S_CB1;
        S_CB1: begin
          acc_q <= prod;
          st_q <= S_CB2;
        end
        S_CB2: begin
          if (flag_q) begin
            pc_q <= comb_r;
          end else begin
            pb_q <= comb_r;
          end
          res_q.probe_point <= comb_r;
          st_q <= S_EMIT;
        end
        S_EMIT: if (!out_valid_q || out_o.ready) begin
          out_q <= res_q;
          res_q <= '0;
          out_valid_q <= 1'b1;
          st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.result_kind   = out_q.result_kind;
  assign out_o.probe_point   = out_q.probe_point;
  assign out_o.bracket_low   = out_q.bracket_low;
  assign out_o.bracket_mid   = out_q.bracket_mid;
  assign out_o.bracket_high  = out_q.bracket_high;
  assign out_o.value_low     = out_q.value_low;
  assign out_o.value_mid     = out_q.value_mid;
  assign out_o.value_high    = out_q.value_high;
  assign out_o.minimum_point = out_q.minimum_point;
  assign out_o.minimum_value = out_q.minimum_value;

  `BGSM_ASSERT_NEXT(a_cmd_leaves_idle, in_beat && (in_i.command != CMD_NONE), st_q != S_IDLE, "accepted beat left sequencer idle")
  `BGSM_ASSERT(a_div_window, div_busy |-> (st_q == S_BT7 || st_q == S_BT8 || st_q == S_BTW), "divider running outside parabolic step")
  `BGSM_ASSERT_NEXT(a_emit_loads, (st_q == S_EMIT) && out_o.ready, out_valid_q && (st_q == S_IDLE), "result not loaded on free output")
endmodule

[sv/bgsm_mul.sv]
// shared signed multiplier with registered product
// depends on bgsm_pkg
module bgsm_mul import bgsm_pkg::*; (
  input  logic    clk_i,
  input  mul_op_t a_i,
  input  mul_op_t b_i,
  output wide_t   p_o
);
  wide_t p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;
endmodule

[sv/bgsm_div.sv]
// unsigned restoring divider, one quotient bit per cycle
// depends on bgsm_pkg
module bgsm_div import bgsm_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DivW-1:0] dividend_i,
  input  logic [DvsW-1:0] divisor_i,
  output logic            busy_o,
  output logic [DivW-1:0] quotient_o
);
  localparam int unsigned CntW = $clog2(DivW + 1);

  logic [CntW-1:0] cnt_q;
  logic [DivW-1:0] quo_q;
  logic [DvsW-1:0] rem_q;
  logic [DvsW-1:0] dvs_q;
  logic [DvsW:0]   trial;

  assign trial = {rem_q, quo_q[DivW-1]} - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CntW'(DivW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      if (!trial[DvsW]) begin
        rem_q <= trial[DvsW-1:0];
        quo_q <= {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[DvsW-2:0], quo_q[DivW-1]};
        quo_q <= {quo_q[DivW-2:0], 1'b0};
      end
    end
  end

  assign busy_o     = (cnt_q != '0);
  assign quotient_o = quo_q;
endmodule

[tb/tb_bgsm_checker.sv]
// result checker of the bracket and golden-section search controller
// depends on bgsm_pkg and the channel interfaces of bgsm_if.sv
module tb_bgsm_checker import bgsm_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  bgsm_in_if   in_mon,
  bgsm_out_if  out_mon,
  bgsm_cfg_if  cfg_mon,
  output int   fail_cnt_o,
  output int   pending_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_BR_FA, ST_BR_FB, ST_BR_FC, ST_BR_IN, ST_BR_OUT, ST_BR_SHIFT,
    ST_GS_F1, ST_GS_F2, ST_GS_N1, ST_GS_N2
  } search_step_e;

  logic signed [31:0] pt [4];
  logic signed [31:0] fval [3];
  logic [23:0]        tol_q24;
  search_step_e       step_q;
  out_item_t          expected_q [$];

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint round_shr(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [31:0] scale_q24(input logic signed [31:0] x,
                                                   input longint k);
    return clamp32(round_shr(longint'(x) * k, 24));
  endfunction

  function automatic logic signed [31:0] blend_golden(input logic signed [31:0] p,
                                                      input logic signed [31:0] q);
    return clamp32(round_shr(longint'(p) * longint'(RatioQ24) +
                             longint'(q) * longint'(CompQ24), 24));
  endfunction

  function automatic int sgn(input longint v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  function automatic longint mag64(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic out_item_t probe_at(input logic signed [31:0] p);
    out_item_t r;
    r = '0;
    r.result_kind = KIND_PROBE;
    r.probe_point = p;
    return r;
  endfunction

  function automatic logic signed [31:0] golden_outward();
    return clamp32(longint'(pt[2]) +
                   longint'(scale_q24(clamp32(longint'(pt[2]) - pt[1]), longint'(GoldQ24))));
  endfunction

  function automatic void shift_bracket(input logic signed [31:0] fu);
    pt[0] = pt[1];
    pt[1] = pt[2];
    pt[2] = pt[3];
    fval[0] = fval[1];
    fval[1] = fval[2];
    fval[2] = fu;
  endfunction

  function automatic out_item_t bracket_check();
    out_item_t r;
    logic signed [31:0] a, b, c, fa, fb, fc, dba, dbc, rr, q, u, ulim;
    longint num, den, dmag, quot;
    a = pt[0]; b = pt[1]; c = pt[2];
    fa = fval[0]; fb = fval[1]; fc = fval[2];
    if (!(fb >= fc) || (fb == 0 && fc == 0) || b == c) begin
      step_q = ST_IDLE;
      r = '0;
      r.result_kind  = KIND_BRACKET;
      r.bracket_low  = a;
      r.bracket_mid  = b;
      r.bracket_high = c;
      r.value_low    = fa;
      r.value_mid    = fb;
      r.value_high   = fc;
      return r;
    end
    dba = clamp32(longint'(b) - a);
    dbc = clamp32(longint'(b) - c);
    rr = clamp32(round_shr(longint'(dba) * clamp32(longint'(fb) - fc), FRAC_BITS));
    q  = clamp32(round_shr(longint'(dbc) * clamp32(longint'(fb) - fa), FRAC_BITS));
    num = longint'(dbc) * q - longint'(dba) * rr;
    den = longint'(q) - rr;
    dmag = mag64(den);
    if (dmag < 1) dmag = 1;
    quot = num / (2 * dmag);
    if (den <= 0) quot = -quot;
    u = clamp32(longint'(b) - quot);
    ulim = clamp32(longint'(b) + clamp32(longint'(GrowLimit) * clamp32(longint'(c) - b)));
    if (sgn(longint'(b) - u) * sgn(longint'(u) - c) > 0) begin
      step_q = ST_BR_IN;
    end else if (sgn(longint'(c) - u) * sgn(longint'(u) - ulim) > 0) begin
      step_q = ST_BR_OUT;
    end else if (sgn(longint'(u) - ulim) * sgn(longint'(ulim) - c) >= 0) begin
      u = ulim;
      step_q = ST_BR_SHIFT;
    end else begin
      u = golden_outward();
      step_q = ST_BR_SHIFT;
    end
    pt[3] = u;
    return probe_at(u);
  endfunction

  function automatic out_item_t golden_check();
    out_item_t r;
    logic signed [31:0] x0, x1, x2, x3;
    longint width;
    longint unsigned span;
    x0 = pt[0]; x1 = pt[1]; x2 = pt[2]; x3 = pt[3];
    width = mag64(longint'(x3) - x0);
    span = longint'(mag64(longint'(x1))) + longint'(mag64(longint'(x2)));
    if (width > 4 &&
        (longint'(unsigned'(width)) << 24) > longint'(unsigned'(longint'(tol_q24) * span))) begin
      if (fval[1] < fval[0]) begin
        pt[0] = x1;
        pt[1] = x2;
        pt[2] = blend_golden(x2, x3);
        fval[0] = fval[1];
        step_q = ST_GS_N2;
        return probe_at(pt[2]);
      end
      pt[3] = x2;
      pt[2] = x1;
      pt[1] = blend_golden(x1, x0);
      fval[1] = fval[0];
      step_q = ST_GS_N1;
      return probe_at(pt[1]);
    end
    step_q = ST_IDLE;
    r = '0;
    r.result_kind = KIND_MINIMUM;
    if (fval[0] < fval[1]) begin
      r.minimum_point = x1;
      r.minimum_value = fval[0];
    end else begin
      r.minimum_point = x2;
      r.minimum_value = fval[1];
    end
    return r;
  endfunction

  function automatic out_item_t search_predict(input logic [1:0] cmd,
                                               input logic signed [31:0] lo,
                                               input logic signed [31:0] mi,
                                               input logic signed [31:0] hi,
                                               input logic signed [31:0] fv);
    out_item_t r;
    logic signed [31:0] t, u;
    if (cmd == CMD_BRACKET) begin
      pt[0] = lo;
      pt[1] = mi;
      step_q = ST_BR_FA;
      return probe_at(lo);
    end
    if (cmd == CMD_GOLDEN) begin
      pt[0] = lo;
      pt[3] = hi;
      if (mag64(longint'(hi) - mi) > mag64(longint'(mi) - lo)) begin
        pt[1] = mi;
        pt[2] = clamp32(longint'(mi) +
                        scale_q24(clamp32(longint'(hi) - mi), longint'(CompQ24)));
      end else begin
        pt[2] = mi;
        pt[1] = clamp32(longint'(mi) -
                        scale_q24(clamp32(longint'(mi) - lo), longint'(CompQ24)));
      end
      step_q = ST_GS_F1;
      return probe_at(pt[1]);
    end
    case (step_q)
      ST_BR_FA: begin
        fval[0] = fv;
        step_q = ST_BR_FB;
        return probe_at(pt[1]);
      end
      ST_BR_FB: begin
        fval[1] = fv;
        if (fval[1] > fval[0]) begin
          t = pt[0]; pt[0] = pt[1]; pt[1] = t;
          t = fval[0]; fval[0] = fval[1]; fval[1] = t;
        end
        t = clamp32(longint'(pt[1]) +
                    scale_q24(clamp32(longint'(pt[1]) - pt[0]), longint'(GoldQ24)));
        pt[2] = clamp32(mag64(longint'(t)));
        step_q = ST_BR_FC;
        return probe_at(pt[2]);
      end
      ST_BR_FC: begin
        fval[2] = fv;
        return bracket_check();
      end
      ST_BR_IN: begin
        u = pt[3];
        if (fv < fval[2]) begin
          pt[0] = pt[1];
          fval[0] = fval[1];
          pt[1] = u;
          fval[1] = fv;
          return bracket_check();
        end
        if (fv > fval[1]) begin
          pt[2] = u;
          fval[2] = fv;
          return bracket_check();
        end
        u = golden_outward();
        pt[3] = u;
        step_q = ST_BR_SHIFT;
        return probe_at(u);
      end
      ST_BR_OUT: begin
        if (fv < fval[2]) begin
          pt[1] = pt[2];
          pt[2] = pt[3];
          fval[1] = fval[2];
          fval[2] = fv;
          u = golden_outward();
          pt[3] = u;
          step_q = ST_BR_SHIFT;
          return probe_at(u);
        end
        shift_bracket(fv);
        return bracket_check();
      end
      ST_BR_SHIFT: begin
        shift_bracket(fv);
        return bracket_check();
      end
      ST_GS_F1: begin
        fval[0] = fv;
        step_q = ST_GS_F2;
        return probe_at(pt[2]);
      end
      ST_GS_F2, ST_GS_N2: begin
        fval[1] = fv;
        return golden_check();
      end
      ST_GS_N1: begin
        fval[0] = fv;
        return golden_check();
      end
      default: begin
        step_q = ST_IDLE;
        r = '0;
        r.result_kind = KIND_ERROR;
        return r;
      end
    endcase
  endfunction

  task automatic field_check(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_cnt_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t e;
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) pt[i] = '0;
      for (int i = 0; i < 3; i++) fval[i] = '0;
      tol_q24 = TolReset;
      step_q = ST_IDLE;
      expected_q.delete();
      fail_cnt_o = 0;
      pending_o = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          $error("result beat with nothing expected");
          fail_cnt_o++;
        end else begin
          e = expected_q.pop_front();
          field_check("result_kind", 32'(e.result_kind), 32'(out_mon.result_kind));
          field_check("probe_point", e.probe_point, out_mon.probe_point);
          field_check("bracket_low", e.bracket_low, out_mon.bracket_low);
          field_check("bracket_mid", e.bracket_mid, out_mon.bracket_mid);
          field_check("bracket_high", e.bracket_high, out_mon.bracket_high);
          field_check("value_low", e.value_low, out_mon.value_low);
          field_check("value_mid", e.value_mid, out_mon.value_mid);
          field_check("value_high", e.value_high, out_mon.value_high);
          field_check("minimum_point", e.minimum_point, out_mon.minimum_point);
          field_check("minimum_value", e.minimum_value, out_mon.minimum_value);
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) tol_q24 = cfg_mon.tolerance;
      if (in_mon.valid && in_mon.ready && in_mon.command != CMD_NONE) begin
        expected_q.push_back(search_predict(in_mon.command, in_mon.start_low,
                                            in_mon.start_mid, in_mon.start_high,
                                            in_mon.function_value));
      end
      pending_o = expected_q.size();
    end
  end

endmodule

[tb/tb_bracket_and_golden_section_minimizer.sv]
// stimulus and verdict for the bracket and golden-section search controller
// depends on bgsm_pkg, bgsm_if.sv, the rtl top and tb_bgsm_checker
module tb_bracket_and_golden_section_minimizer import bgsm_pkg::*;;

  localparam int CycleLimit = 1500000;

  logic clk_i;
  logic rst_ni;
  int   snd_idle, rcv_idle;
  int   beats_sent, res_cnt, n_bracket, n_minimum, cycles;
  int   fail_cnt, pending;
  logic [1:0]         last_kind;
  logic signed [31:0] last_probe;
  int                 fn_shape;
  logic signed [31:0] fn_centre, fn_level;

  bgsm_in_if  in_ch ();
  bgsm_out_if out_ch ();
  bgsm_cfg_if cfg_ch ();

  bracket_and_golden_section_minimizer DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  tb_bgsm_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .cfg_mon   (cfg_ch),
    .fail_cnt_o(fail_cnt),
    .pending_o (pending)
  );

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_bracket_and_golden_section_minimizer failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ch.ready <= rst_ni && ($urandom_range(99) >= rcv_idle);
    if (out_ch.valid && out_ch.ready) begin
      res_cnt    <= res_cnt + 1;
      last_kind  <= out_ch.result_kind;
      last_probe <= out_ch.probe_point;
      if (out_ch.result_kind == KIND_BRACKET) n_bracket <= n_bracket + 1;
      if (out_ch.result_kind == KIND_MINIMUM) n_minimum <= n_minimum + 1;
    end
  end

  function automatic logic signed [31:0] rand_point();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(1 << 22)) - (1 << 21);
    endcase
  endfunction

  function automatic logic signed [31:0] sample_fn(input logic signed [31:0] x);
    longint d;
    longint v;
    case (fn_shape)
      0: begin
        d = (longint'(x) - fn_centre) >>> 8;
        v = d * d + fn_level;
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        return v[31:0];
      end
      1: return '0;
      2: return $urandom;
      default: return fn_level;
    endcase
  endfunction

  task automatic push_item(input logic [1:0] cmd, input logic signed [31:0] lo,
                           input logic signed [31:0] mi, input logic signed [31:0] hi,
                           input logic signed [31:0] fv);
    int snap;
    snap = res_cnt;
    if ($urandom_range(99) < snd_idle) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < snd_idle);
    end
    in_ch.command        <= cmd;
    in_ch.start_low      <= lo;
    in_ch.start_mid      <= mi;
    in_ch.start_high     <= hi;
    in_ch.function_value <= fv;
    in_ch.valid          <= 1'b1;
    do @(posedge clk_i); while (!(in_ch.valid && in_ch.ready));
    beats_sent++;
    if (cmd != CMD_NONE) begin
      in_ch.valid <= 1'b0;
      while (res_cnt == snap) @(posedge clk_i);
    end
  endtask

  task automatic reply(input logic signed [31:0] fv);
    push_item(CMD_REPLY, $urandom, $urandom, $urandom, fv);
  endtask

  task automatic run_search(input logic [1:0] cmd, input logic signed [31:0] lo,
                            input logic signed [31:0] mi, input logic signed [31:0] hi,
                            input int cap);
    int n;
    push_item(cmd, lo, mi, hi, $urandom);
    n = 0;
    while (last_kind == KIND_PROBE && n < cap) begin
      reply(sample_fn(last_probe));
      n++;
    end
  endtask

  task automatic pick_shape();
    int r;
    r = $urandom_range(9);
    fn_shape  = (r < 7) ? 0 : r - 6;
    fn_centre = rand_point();
    fn_level  = $signed($urandom_range(1 << 20)) - (1 << 19);
  endtask

  task automatic random_search();
    logic signed [31:0] lo, mi, hi;
    int span;
    pick_shape();
    if ($urandom_range(1)) begin
      lo = rand_point();
      mi = $urandom_range(3) ? lo + $signed($urandom_range(1 << 18)) - (1 << 17)
                             : rand_point();
      run_search(CMD_BRACKET, lo, mi, $urandom, 40);
    end else begin
      span = $urandom_range(3) ? $urandom_range(8, 1 << 20) : $urandom_range(8, 1 << 30);
      lo = $signed($urandom_range(1 << 22)) - (1 << 21);
      mi = lo + $signed($urandom_range(span));
      hi = lo + span;
      if ($urandom_range(7) == 0) begin
        lo = rand_point(); mi = rand_point(); hi = rand_point();
      end
      run_search(CMD_GOLDEN, lo, mi, hi, 70);
    end
  endtask

  task automatic settle_and_write(input logic [23:0] tol);
    fn_shape = 2;
    run_search(CMD_GOLDEN, 0, 2, 4, 10);
    while (pending != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
    cfg_ch.tolerance <= tol;
    cfg_ch.valid     <= 1'b1;
    do @(posedge clk_i); while (!(cfg_ch.valid && cfg_ch.ready));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_phase(input int target);
    while (beats_sent < target) begin
      case ($urandom_range(11))
        0: push_item(CMD_NONE, $urandom, $urandom, $urandom, $urandom);
        1: reply($urandom);
        default: random_search();
      endcase
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cycles = 0; beats_sent = 0; res_cnt = 0; n_bracket = 0; n_minimum = 0;
    last_kind = KIND_ERROR; last_probe = '0;
    snd_idle = 9; rcv_idle = 50;
    fn_shape = 0; fn_centre = '0; fn_level = '0;
    in_ch.valid = 1'b0; in_ch.command = CMD_NONE; in_ch.start_low = '0;
    in_ch.start_mid = '0; in_ch.start_high = '0; in_ch.function_value = '0;
    cfg_ch.valid = 1'b0; cfg_ch.tolerance = '0;
    out_ch.ready = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    settle_and_write(24'd168);

    // reply while idle, ignored command
    reply(32'sh7fffffff);
    push_item(CMD_NONE, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh80000000);
    // extreme starts, all-zero values end bracketing at once
    fn_shape = 1;
    run_search(CMD_BRACKET, 32'sh80000000, 32'sh7fffffff, 0, 6);
    // equal starting points give a degenerate bracket
    fn_shape = 3; fn_level = 32'sd7 <<< 16;
    run_search(CMD_BRACKET, 32'sd5 <<< 16, 32'sd5 <<< 16, 0, 6);
    // golden start on the full range, then a new start abandons it
    fn_shape = 0; fn_centre = 32'sd3 <<< 16; fn_level = -32'sd1;
    push_item(CMD_GOLDEN, 32'sh80000000, 0, 32'sh7fffffff, 0);
    reply(sample_fn(last_probe));
    reply(sample_fn(last_probe));
    push_item(CMD_BRACKET, 0, 32'sd1 <<< 16, 0, 0);
    reply(sample_fn(last_probe));
    push_item(CMD_GOLDEN, 32'sh7fffffff, 32'sh7ffffff0, 32'sh80000000, 0);
    reply(32'sh80000000);
    reply(32'sh7fffffff);
    run_search(CMD_GOLDEN, 0, 2, 4, 6);

    random_phase(360);
    settle_and_write(24'd0);
    snd_idle = 50; rcv_idle = 9;
    random_phase(700);
    settle_and_write(24'hffffff);
    snd_idle = 0; rcv_idle = 0;
    random_phase(880);
    settle_and_write($urandom_range(1, 24'hfffffe));
    random_phase(1050);

    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("%0d input beats, %0d results: %0d brackets, %0d minima, four tolerances",
             beats_sent, res_cnt, n_bracket, n_minimum);
    if (fail_cnt == 0) begin
      $display("tb_bracket_and_golden_section_minimizer passed");
    end else begin
      $display("tb_bracket_and_golden_section_minimizer failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/bgsm_pkg.sv
sv/bgsm_if.sv
sv/bgsm_mul.sv
sv/bgsm_div.sv
sv/bracket_and_golden_section_minimizer.sv
tb/tb_bgsm_checker.sv
tb/tb_bracket_and_golden_section_minimizer.sv
